// ===== src/skf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Payload structs, register indexes, fixed-point widths and reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int VAL_W    = 32;             // Q16.16 values
    localparam int GAIN_BITS = 16;            // gain fraction bits
    localparam int GAIN_W   = GAIN_BITS + 1;  // gain 0..1.0 inclusive
    localparam int MAG_W    = VAL_W + 1;      // |sample - estimate|, below 2^32
    localparam int REM_W    = VAL_W + 2;      // divider partial remainder
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

    localparam logic [VAL_W-1:0] RST_PROCESS_NOISE      = VAL_W'(6554);
    localparam logic [VAL_W-1:0] RST_MEASURE_NOISE      = VAL_W'(6554);
    localparam logic [VAL_W-1:0] RST_INITIAL_ESTIMATE   = VAL_W'(0);
    localparam logic [VAL_W-1:0] RST_INITIAL_COVARIANCE = VAL_W'(6554);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS_NOISE      = 2'd0,
        REG_MEASURE_NOISE      = 2'd1,
        REG_INITIAL_ESTIMATE   = 2'd2,
        REG_INITIAL_COVARIANCE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_value;
        logic                    run_last;
    } in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] filtered_value;
        logic [GAIN_W-1:0]       gain_value;
        logic                    math_error;
        logic                    run_end;
    } out_t;

endpackage

// ===== src/skf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_div: radix-2 gain divider
// Restoring division (num << 16) / den, one quotient bit per cycle.
// Requires num <= den, so the quotient fits in 17 bits.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [skf_pkg::VAL_W-1:0]    num,
    input  logic [skf_pkg::VAL_W:0]      den,
    output logic                         done,
    output logic [skf_pkg::GAIN_W-1:0]   quot
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [VAL_W:0]    den_reg;
    logic [GAIN_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;
    logic [REM_W-1:0]  rem_sub;
    logic [REM_W-1:0]  rem_keep;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        rem_sub   = rem_reg - {1'b0, den_reg};
        rem_keep  = ge ? rem_sub : rem_reg;
        rem_next  = {rem_keep[REM_W-2:0], 1'b0};
        quot_next = {quot_reg[GAIN_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= REM_W'(num);
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== src/skf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_mul: serial gain multiplier
// Shift-add over the 17 gain bits, LSB first; returns (mcand * mplier) >> 16.
// ----------------------------------------------------------------------------
module skf_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [skf_pkg::MAG_W-1:0]    mcand,
    input  logic [skf_pkg::GAIN_W-1:0]   mplier,
    output logic                         done,
    output logic [skf_pkg::MAG_W-1:0]   prod
);
    import skf_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

    logic [MAG_W-1:0]  mc_reg;
    logic [GAIN_W-1:0] mp_reg;
    logic [MAG_W-1:0]  acc_reg;
    logic              lsb_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MAG_W:0]    sum;

    // product bits shift out at the bottom; the last one out is bit 16
    assign sum = {1'b0, acc_reg} + (mp_reg[0] ? {1'b0, mc_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mc_reg  <= mcand;
            mp_reg  <= mplier;
            acc_reg <= '0;
            lsb_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            mp_reg  <= mp_reg >> 1;
            acc_reg <= sum[MAG_W:1];
            lsb_reg <= sum[0];
        end
    end

    assign done = done_reg;
    assign prod = {acc_reg[MAG_W-2:0], lsb_reg};

endmodule

// ===== src/scalar_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman filter, fixed point
// One sample in flight: a new sample is taken only once the previous result has
//   gone through the 17-step radix-2 gain divider and the two 17-step serial
//   multipliers, which run together, and is in the output register.
// A new sample is accepted while a finished result waits in the output register.
// Reset: async active low; control/config/filter state load documented defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  skf_pkg::in_t                      in_data,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output skf_pkg::out_t                     out_data,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [skf_pkg::VAL_W-1:0]         cfg_data
);
    import skf_pkg::*;

    // One-hot sequencer: prepare, divide, multiply, update, deliver
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_UPD  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [VAL_W-1:0]        q_reg;
    logic [VAL_W-1:0]        r_reg;

    // filter state
    logic signed [VAL_W-1:0] est_reg;
    logic [VAL_W-1:0]        cov_reg;

    // per-transaction working registers
    logic signed [VAL_W-1:0] sample_reg;
    logic                    last_reg;
    logic [VAL_W-1:0]        p1_reg;      // predicted covariance, saturated
    logic                    err_reg;
    logic [VAL_W:0]          den_reg;
    logic                    den_zero_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic                    div_start_reg;
    logic                    mul_start_reg;
    logic signed [VAL_W-1:0] x_new_reg;

    // output register
    logic                    out_valid_reg;
    out_t                    out_data_reg;

    // datapath
    logic [VAL_W:0]          p1_sum;
    logic [VAL_W:0]          den_sum;
    logic signed [VAL_W:0]   diff;
    logic                    div_done;
    logic [GAIN_W-1:0]       div_quot;
    logic                    mul_x_done;
    logic                    mul_p_done;
    logic [MAG_W-1:0]        step_mag;
    logic [MAG_W-1:0]        cov_prod;
    logic [GAIN_W-1:0]       one_minus_gain;
    logic signed [VAL_W+1:0] x_sum;
    logic                    in_xact;
    logic                    out_free;

    assign in_xact  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // prediction: P + q, saturating to 32 bits
    assign p1_sum  = {1'b0, cov_reg} + {1'b0, q_reg};
    // denominator r + P' (33 bits, no overflow)
    assign den_sum = {1'b0, r_reg} + {1'b0, p1_reg};
    // innovation, sign and magnitude for the serial multiply
    assign diff    = {sample_reg[VAL_W-1], sample_reg} - {est_reg[VAL_W-1], est_reg};

    assign one_minus_gain = GAIN_ONE - gain_reg;

    // estimate moves toward the sample by the truncated step
    assign x_sum = neg_reg ? ({{2{est_reg[VAL_W-1]}}, est_reg} - {1'b0, step_mag})
                           : ({{2{est_reg[VAL_W-1]}}, est_reg} + {1'b0, step_mag});

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (p1_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // gain * |innovation| >> 16
    skf_mul u_mul_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .mcand  (mag_reg),
        .mplier (gain_reg),
        .done   (mul_x_done),
        .prod   (step_mag)
    );

    // P' * (1 - gain) >> 16
    skf_mul u_mul_p (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .mcand  ({1'b0, p1_reg}),
        .mplier (one_minus_gain),
        .done   (mul_p_done),
        .prod   (cov_prod)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_xact) state_next = S_PREP;
            S_PREP: state_next = S_DIV;
            S_DIV:  if (div_done) state_next = S_MUL;
            S_MUL:  if (mul_x_done) state_next = S_UPD;
            S_UPD:  state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            q_reg         <= RST_PROCESS_NOISE;
            r_reg         <= RST_MEASURE_NOISE;
            est_reg       <= RST_INITIAL_ESTIMATE;
            cov_reg       <= RST_INITIAL_COVARIANCE;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= (state_reg == S_PREP);
            mul_start_reg <= (state_reg == S_DIV) && div_done;

            // user writes config only while idle, unenforced; est/cov reload
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_PROCESS_NOISE:      q_reg   <= cfg_data;
                    REG_MEASURE_NOISE:      r_reg   <= cfg_data;
                    REG_INITIAL_ESTIMATE:   est_reg <= cfg_data;
                    REG_INITIAL_COVARIANCE: cov_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_UPD)
            begin
                est_reg <= x_sum[VAL_W-1:0];
                cov_reg <= cov_prod[VAL_W-1:0];
            end

            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            sample_reg <= in_data.sample_value;
            last_reg   <= in_data.run_last;
            p1_reg     <= p1_sum[VAL_W] ? '1 : p1_sum[VAL_W-1:0];
            err_reg    <= p1_sum[VAL_W];
        end

        if (state_reg == S_PREP)
        begin
            den_reg      <= den_sum;
            den_zero_reg <= (den_sum == '0);
            neg_reg      <= diff[VAL_W];
            mag_reg      <= diff[VAL_W] ? MAG_W'(-diff) : MAG_W'(diff);
        end

        if (state_reg == S_DIV && div_done)
        begin
            // zero denominator: gain 0, state carries through unchanged
            gain_reg <= den_zero_reg ? '0 : div_quot;
            err_reg  <= err_reg || den_zero_reg;
        end

        if (state_reg == S_UPD)
            x_new_reg <= x_sum[VAL_W-1:0];

        if (state_reg == S_OUT && out_free)
        begin
            out_data_reg.filtered_value <= x_new_reg;
            out_data_reg.gain_value     <= gain_reg;
            out_data_reg.math_error     <= err_reg;
            out_data_reg.run_end        <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (gain_reg <= GAIN_ONE))
        else $error("gain above 1.0");

    a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |=> (cov_reg <= $past(p1_reg)))
        else $error("covariance grew in update");

    a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && den_zero_reg) |-> (gain_reg == '0 && err_reg))
        else $error("zero denominator not flagged");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide phase");

    a_muls_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_x_done == mul_p_done)
        else $error("multipliers out of step");

endmodule
